// ===== rtl/i2c_slave_command_mailbox_defines.svh =====
// Assertion macros for the I2C slave command mailbox.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef I2C_SLAVE_COMMAND_MAILBOX_DEFINES_SVH
`define I2C_SLAVE_COMMAND_MAILBOX_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define I2CMB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox check failed");
// Next-cycle implication, disabled during reset
`define I2CMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox check failed");
`else
`define I2CMB_ASSERT_IMPL(label, ante, cons)
`define I2CMB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/i2cmb_pkg.sv =====
// Shared types and constants for the I2C slave command mailbox.
// No dependencies.
`default_nettype none

package i2cmb_pkg;

    // Sizes
    localparam int SLOT_COUNT    = 4;
    localparam int PAYLOAD_BYTES = 3;
    localparam int REPLY_BYTES   = 2;
    localparam int ORDER_BYTES   = 3;

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PCNT_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int RCNT_W  = (REPLY_BYTES > 1) ? $clog2(REPLY_BYTES) : 1;
    localparam int PHASE_W = 3;
    localparam int KIND_W  = 3;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;

    // First command byte of an rgb slot write
    localparam logic [3:0] CMD_RGB_BASE = 4'd4;

    // Response kinds
    localparam logic [KIND_W-1:0] KIND_BUTTONS = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

    // Transaction phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ADC0 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ADC1 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ENC  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BUT  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RGB  = 3'd5;

    typedef struct packed {
        logic [1:0] mode;
        logic       is_first;
        logic [3:0] command;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [2:0] response_kind;
        logic       response_index;
        logic       order_valid;
        logic [1:0] order_slot;
        logic [7:0] order_byte_zero;
        logic [7:0] order_byte_one;
        logic [7:0] order_byte_two;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_slave_command_mailbox.sv =====
// I2C slave command mailbox: command decode, rgb order slots, fetch of ready orders.
// Depends on i2cmb_pkg and i2c_slave_command_mailbox_defines.svh.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one event of the I2C layer:
//   a written byte, a read byte request, or a fetch of a ready rgb order.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result per
//   accepted command, in order.
//   Each result is registered, in the response register or, while rsp_stall is
//   high, in the skid register. Throughput: one command per cycle while cmd_stall
//   is low; decode and slot update sit between cmd port and response register.
//   A skid register holds one more result while rsp_stall is high, so the block
//   still takes a command in that cycle; cmd_stall rises only while the skid
//   register is full and drops once the receiver takes a result.
//   Reset: phase idle, counters cleared, all slots not ready, no result pending.
//   Slot bytes are not reset; a fetch only returns fully written slots.
`default_nettype none
`include "i2c_slave_command_mailbox_defines.svh"

module i2c_slave_command_mailbox
    import i2cmb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    // Control state
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [RCNT_W-1:0]   reply_count_reg, reply_count_next;
    logic [PCNT_W-1:0]   payload_count_reg, payload_count_next;
    logic [SLOT_W-1:0]   sel_reg, sel_next;
    logic [SLOT_COUNT-1:0] slot_ready_reg, slot_ready_next;

    // Slot payload storage
    logic [7:0] slot_bytes_reg [SLOT_COUNT][PAYLOAD_BYTES];
    logic       byte_we;

    // Output and skid registers
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    rsp_t out_data_reg, out_data_next;
    rsp_t skid_data_reg, skid_data_next;

    logic accept;
    logic out_load;
    rsp_t result;

    // Fetch search
    logic              fetch_hit;
    logic [SLOT_W-1:0] fetch_slot;
    logic [7:0]        ord_bytes [ORDER_BYTES];
    logic              fetch_take;

    assign accept   = cmd_valid && !skid_valid_reg;
    assign out_load = !out_valid_reg || !rsp_stall;

    assign cmd_stall = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    assign fetch_take = accept && cmd.mode == MODE_FETCH && fetch_hit;

    // Lowest ready slot
    always_comb
    begin
        fetch_hit  = 1'b0;
        fetch_slot = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (slot_ready_reg[s])
            begin
                fetch_hit  = 1'b1;
                fetch_slot = SLOT_W'(s);
            end
        end
    end

    // Bytes of the fetched slot; positions past the payload read as zero
    always_comb
    begin
        for (int b = 0; b < ORDER_BYTES; b++)
        begin
            if (b < PAYLOAD_BYTES)
                ord_bytes[b] = slot_bytes_reg[fetch_slot][PCNT_W'(b)];
            else
                ord_bytes[b] = 8'd0;
        end
    end

    // Command decode and state transition
    always_comb
    begin
        phase_next         = phase_reg;
        reply_count_next   = reply_count_reg;
        payload_count_next = payload_count_reg;
        sel_next           = sel_reg;
        slot_ready_next    = slot_ready_reg;
        byte_we            = 1'b0;
        result             = '0;
        result.response_kind = KIND_NONE;

        case (cmd.mode)
            MODE_WRITE:
            begin
                if (cmd.is_first)
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        reply_count_next   = '0;
                        payload_count_next = '0;
                        sel_next           = '0;
                        if (cmd.command < CMD_RGB_BASE)
                            phase_next = PH_ADC0 + PHASE_W'(cmd.command[1:0]);
                        else if (int'(cmd.command) < int'(CMD_RGB_BASE) + SLOT_COUNT)
                        begin
                            if (!slot_ready_reg[SLOT_W'(cmd.command - CMD_RGB_BASE)])
                            begin
                                sel_next   = SLOT_W'(cmd.command - CMD_RGB_BASE);
                                phase_next = PH_RGB;
                            end
                        end
                    end
                end
                else if (phase_reg == PH_RGB)
                begin
                    byte_we = 1'b1;
                    if (int'(payload_count_reg) == PAYLOAD_BYTES - 1)
                    begin
                        payload_count_next       = '0;
                        slot_ready_next[sel_reg] = 1'b1;
                        phase_next               = PH_IDLE;
                    end
                    else
                        payload_count_next = payload_count_reg + 1'b1;
                end
                else
                begin
                    payload_count_next = '0;
                    phase_next         = PH_IDLE;
                end
            end
            MODE_READ:
            begin
                if (phase_reg == PH_ADC0 || phase_reg == PH_ADC1 || phase_reg == PH_ENC)
                begin
                    result.response_kind  = KIND_W'(phase_reg - PH_ADC0);
                    result.response_index = reply_count_reg[0];
                    if (int'(reply_count_reg) == REPLY_BYTES - 1)
                    begin
                        reply_count_next = '0;
                        phase_next       = PH_IDLE;
                    end
                    else
                        reply_count_next = reply_count_reg + 1'b1;
                end
                else
                begin
                    result.response_kind = (phase_reg == PH_BUT) ? KIND_BUTTONS : KIND_ERROR;
                    reply_count_next     = '0;
                    phase_next           = PH_IDLE;
                end
            end
            MODE_FETCH:
            begin
                if (fetch_hit)
                begin
                    slot_ready_next[fetch_slot] = 1'b0;
                    result.order_valid     = 1'b1;
                    result.order_slot      = 2'(fetch_slot);
                    result.order_byte_zero = ord_bytes[0];
                    result.order_byte_one  = ord_bytes[1];
                    result.order_byte_two  = ord_bytes[2];
                end
            end
            default:
            begin
                // no effect; result stays kind none
            end
        endcase
    end

    // Output register and skid steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            reply_count_reg   <= '0;
            payload_count_reg <= '0;
            sel_reg           <= '0;
            slot_ready_reg    <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                reply_count_reg   <= reply_count_next;
                payload_count_reg <= payload_count_next;
                sel_reg           <= sel_next;
                slot_ready_reg    <= slot_ready_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && byte_we)
            slot_bytes_reg[sel_reg][payload_count_reg] <= cmd.data_byte;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Checks
    `I2CMB_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `I2CMB_ASSERT_IMPL(a_rgb_slot_free, phase_reg == PH_RGB, !slot_ready_reg[sel_reg])
    `I2CMB_ASSERT_NEXT(a_fetch_clears, fetch_take, !slot_ready_reg[$past(fetch_slot)])

endmodule

`default_nettype wire
